// File: rtl/windowed_stddev_activity_detector_top_assert.svh
// Assertion macros shared by the activity detector RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef WINDOWED_STDDEV_ACTIVITY_DETECTOR_TOP_ASSERT_SVH
`define WINDOWED_STDDEV_ACTIVITY_DETECTOR_TOP_ASSERT_SVH

// Condition must hold in the same cycle as the trigger
`define WSAD_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsad: assertion failed");

// Condition must hold in the cycle after the trigger
`define WSAD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsad: assertion failed");

// Condition must hold at every clock edge out of reset
`define WSAD_ASSERT_ALWAYS(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("wsad: assertion failed");

`endif

// File: rtl/wsad_pkg.sv
// Shared types and constants for the windowed standard deviation activity detector.
// No dependencies; imported by every module of the block.
package wsad_pkg;

  // Fixed field widths
  localparam int THR_BITS      = 12;
  localparam int RUN_BITS      = 8;
  localparam int FRAME_BITS    = 16;
  localparam int SCALE_BITS    = 16;
  localparam int OFFSET_BITS   = 21;
  localparam int LEN_BITS      = 34;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 21;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_STD_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_RUN      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_RUN       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_EVENT      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH_SCALE   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH_OFFSET  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [THR_BITS-1:0]           RST_STD_THRESHOLD = 12'd100;
  localparam logic [RUN_BITS-1:0]           RST_START_RUN     = 8'd3;
  localparam logic [RUN_BITS-1:0]           RST_STOP_RUN      = 8'd8;
  localparam logic [RUN_BITS-1:0]           RST_MIN_EVENT     = 8'd5;
  localparam logic [SCALE_BITS-1:0]         RST_LENGTH_SCALE  = 16'd21627;
  localparam logic signed [OFFSET_BITS-1:0] RST_LENGTH_OFFSET = -21'sd88785;

  // Saturation limits
  localparam logic [RUN_BITS-1:0]   RUN_MAX   = '1;
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;
  localparam longint LEN_MAX = 64'sd8589934591;
  localparam longint LEN_MIN = -64'sd8589934592;

  // Result queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [THR_BITS-1:0]           std_threshold;
    logic [RUN_BITS-1:0]           start_run;
    logic [RUN_BITS-1:0]           stop_run;
    logic [RUN_BITS-1:0]           min_event_frames;
    logic [SCALE_BITS-1:0]         length_scale_q12;
    logic signed [OFFSET_BITS-1:0] length_offset_q12;
  } wsad_cfg_t;

  typedef struct packed {
    logic                  event_start;
    logic                  event_end;
    logic                  too_short;
    logic [FRAME_BITS-1:0] event_frames;
  } wsad_flags_t;

endpackage

// File: rtl/wsad_front.sv
// Front part: sample window, variance test and run counters of the activity detector.
// Depends on wsad_pkg; feeds one classified beat per sample into the result queue.
module wsad_front #(
  parameter int WINDOW_LEN  = 5,
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wsad_pkg::wsad_cfg_t        cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic                       q_full,
  output logic                       push,
  output wsad_pkg::wsad_flags_t      flags,
  output logic [COUNT_BITS-1:0]      count
);
  import wsad_pkg::*;

  localparam int LOG_N = $clog2(WINDOW_LEN);
  localparam int SUM_W = SAMPLE_BITS + LOG_N;
  localparam int SQ_W  = 2 * SAMPLE_BITS;
  localparam int SSQ_W = 2 * SAMPLE_BITS + LOG_N;
  localparam int V_W   = 2 * SAMPLE_BITS + 2 * LOG_N;
  localparam int THR_W = 2 * THR_BITS + 2 * LOG_N;
  localparam int CMP_W = ((V_W > THR_W) ? V_W : THR_W) + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                   adv;
  logic                   v0, v1, v2;
  logic [SAMPLE_BITS-1:0] window [WINDOW_LEN];
  logic [SUM_W-1:0]       sum_c, sum1;
  logic [SSQ_W-1:0]       ssq_c, ssq1;
  logic [V_W-1:0]         sqsum2, nssq2;
  logic [SQ_W-1:0]        thr_sq;
  logic [THR_W-1:0]       thr_term;
  logic                   busy;

  logic [RUN_BITS-1:0]    busy_run, busy_run_next;
  logic [RUN_BITS-1:0]    quiet_run, quiet_run_next;
  logic                   in_event, in_event_next;
  logic [COUNT_BITS-1:0]  event_count, event_count_next, count_inc;
  logic [31:0]            count_wide;

  // Whole pipeline advances unless the last stage is blocked by a full queue
  assign adv      = !v2 || !q_full;
  assign in_stall = rst || !adv;
  assign push     = v2 && adv;

  // Stage 0: shift the new sample into the window
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) window[i] <= '0;
    end else if (adv) begin
      v0 <= in_valid;
      if (in_valid) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) window[i] <= window[i + 1];
        window[WINDOW_LEN - 1] <= sample;
      end
    end
  end

  // Stage 1: window sum and sum of squares
  always_comb begin
    sum_c = '0;
    ssq_c = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      sum_c = sum_c + SUM_W'(window[i]);
      ssq_c = ssq_c + SSQ_W'(SQ_W'(window[i]) * SQ_W'(window[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum1 <= sum_c;
      ssq1 <= ssq_c;
    end
  end

  // Stage 2: square of the sum and scaled sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqsum2 <= V_W'(sum1) * V_W'(sum1);
      nssq2  <= V_W'(ssq1) * V_W'(WINDOW_LEN);
    end
  end

  // Threshold term N*N*T*T, recomputed every cycle from the register
  always_ff @(posedge clk) begin
    thr_sq   <= SQ_W'(cfg.std_threshold) * SQ_W'(cfg.std_threshold);
    thr_term <= THR_W'(thr_sq) * THR_W'(WINDOW_LEN * WINDOW_LEN);
  end

  // Stage 3: busy test, without a square root
  assign busy = CMP_W'(nssq2) >= (CMP_W'(sqsum2) + CMP_W'(thr_term));

  assign count_inc  = (event_count == COUNT_MAX) ? event_count : event_count + 1'b1;
  assign count_wide = 32'(count_inc);

  // Run counters and event framing
  always_comb begin
    busy_run_next    = busy_run;
    quiet_run_next   = quiet_run;
    in_event_next    = in_event;
    event_count_next = event_count;
    flags            = '0;
    count            = '0;
    if (busy) begin
      busy_run_next  = (busy_run == RUN_MAX) ? busy_run : busy_run + 1'b1;
      quiet_run_next = '0;
      if (in_event) event_count_next = count_inc;
      if (!in_event && (busy_run_next >= cfg.start_run)) begin
        in_event_next     = 1'b1;
        busy_run_next     = '0;
        event_count_next  = '0;
        flags.event_start = 1'b1;
      end
    end else begin
      quiet_run_next = (quiet_run == RUN_MAX) ? quiet_run : quiet_run + 1'b1;
      busy_run_next  = '0;
      if (in_event) begin
        event_count_next = count_inc;
        if (quiet_run_next >= cfg.stop_run) begin
          in_event_next      = 1'b0;
          quiet_run_next     = '0;
          event_count_next   = '0;
          flags.event_frames = (count_wide > 32'(FRAME_MAX)) ? FRAME_MAX
                                                             : count_wide[FRAME_BITS-1:0];
          if (count_wide < 32'(cfg.min_event_frames)) begin
            flags.too_short = 1'b1;
          end else begin
            flags.event_end = 1'b1;
            count           = count_inc;
          end
        end
      end
    end
  end

  // Commit counter state once the beat enters the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_run    <= '0;
      quiet_run   <= '0;
      in_event    <= 1'b0;
      event_count <= '0;
    end else if (push) begin
      busy_run    <= busy_run_next;
      quiet_run   <= quiet_run_next;
      in_event    <= in_event_next;
      event_count <= event_count_next;
    end
  end

endmodule

// File: rtl/wsad_queue.sv
// Short result queue that decouples the detector front from the length back end.
// Depends on wsad_pkg for depth and on the shared assertion macro header.
`include "windowed_stddev_activity_detector_top_assert.svh"
module wsad_queue #(
  parameter int WIDTH = 36
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  import wsad_pkg::*;

  logic [WIDTH-1:0]       entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   fill;

  assign full  = (fill == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign rdata = entries[rd_ptr];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `WSAD_ASSERT_IMP(a_no_push_when_full, clk, rst, push, !full)
  `WSAD_ASSERT_IMP(a_no_pop_when_empty, clk, rst, pop, !empty)
  `WSAD_ASSERT_NEXT(a_push_leaves_data, clk, rst, push && !pop, !empty)
  `WSAD_ASSERT_ALWAYS(a_fill_in_range, clk, rst, fill <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))

endmodule

// File: rtl/wsad_back.sv
// Back part: scales the frame count of an ended event into a Q12 length and drives results.
// Depends on wsad_pkg; pops beats from the result queue.
module wsad_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  wsad_pkg::wsad_cfg_t                    cfg,
  input  logic                                   q_empty,
  input  wsad_pkg::wsad_flags_t                  q_flags,
  input  logic [COUNT_BITS-1:0]                  q_count,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   event_start,
  output logic                                   event_end,
  output logic                                   too_short,
  output logic [wsad_pkg::FRAME_BITS-1:0]        event_frames,
  output logic signed [wsad_pkg::LEN_BITS-1:0]   length_q12
);
  import wsad_pkg::*;

  localparam int PROD_W = COUNT_BITS + SCALE_BITS;
  localparam int S_W    = (PROD_W + 2 > LEN_BITS + 1) ? PROD_W + 2 : LEN_BITS + 1;
  localparam logic signed [S_W-1:0] LMAX = S_W'(LEN_MAX);
  localparam logic signed [S_W-1:0] LMIN = S_W'(LEN_MIN);

  logic                    adv;
  logic                    b1v, b2v;
  wsad_flags_t             b1_flags, b2_flags;
  logic [PROD_W-1:0]       b1_prod;
  logic signed [S_W-1:0]   len_sum, len_sat;
  logic [LEN_BITS-1:0]     b2_len;

  // Both stages move together unless the held result is stalled
  assign adv = !b2v || !out_stall;
  assign pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1v <= 1'b0;
      b2v <= 1'b0;
    end else if (adv) begin
      b1v <= !q_empty;
      b2v <= b1v;
    end
  end

  // Stage 1: frames times scale
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_flags <= q_flags;
      b1_prod  <= PROD_W'(q_count) * PROD_W'(cfg.length_scale_q12);
    end
  end

  // Stage 2: add the offset and clamp to the signed output range
  assign len_sum = $signed(S_W'(b1_prod)) + S_W'(cfg.length_offset_q12);

  always_comb begin
    if (len_sum > LMAX) begin
      len_sat = LMAX;
    end else if (len_sum < LMIN) begin
      len_sat = LMIN;
    end else begin
      len_sat = len_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_flags <= b1_flags;
      b2_len   <= b1_flags.event_end ? len_sat[LEN_BITS-1:0] : '0;
    end
  end

  assign out_valid    = b2v;
  assign event_start  = b2_flags.event_start;
  assign event_end    = b2_flags.event_end;
  assign too_short    = b2_flags.too_short;
  assign event_frames = b2_flags.event_frames;
  assign length_q12   = $signed(b2_len);

endmodule

// File: rtl/windowed_stddev_activity_detector_top.sv
// Top level of the windowed standard deviation activity detector.
// Depends on wsad_pkg, wsad_front, wsad_queue and wsad_back.
//
// One sample is taken per clock while in_stall is low, and one result beat leaves per
// sample; stalls on the result side are absorbed by a four-entry queue until it fills,
// then reach the sample side as in_stall. From acceptance to its result a sample passes
// four front stages (window shift, sums, squares of the sum, run counters) and, after
// the queue, two back stages (scale multiply, then offset add and clamp into the output
// register). Registers are written through cfg_write, cfg_index and cfg_data; the user
// must write them only while idle, the block itself does not enforce it. There is no
// start-up sweep: the window comes out of reset as zeros.
module windowed_stddev_activity_detector_top #(
  parameter int WINDOW_LEN  = 5,
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [wsad_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [wsad_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [SAMPLE_BITS-1:0]                  sample,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    event_start,
  output logic                                    event_end,
  output logic                                    too_short,
  output logic [wsad_pkg::FRAME_BITS-1:0]         event_frames,
  output logic signed [wsad_pkg::LEN_BITS-1:0]    length_q12
);
  import wsad_pkg::*;

  localparam int FLAGS_W = $bits(wsad_flags_t);
  localparam int ENTRY_W = FLAGS_W + COUNT_BITS;

  wsad_cfg_t             cfg;
  logic                  push, pop, q_full, q_empty;
  wsad_flags_t           f_flags, q_flags;
  logic [COUNT_BITS-1:0] f_count, q_count;
  logic [ENTRY_W-1:0]    q_rdata;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.std_threshold     <= RST_STD_THRESHOLD;
      cfg.start_run         <= RST_START_RUN;
      cfg.stop_run          <= RST_STOP_RUN;
      cfg.min_event_frames  <= RST_MIN_EVENT;
      cfg.length_scale_q12  <= RST_LENGTH_SCALE;
      cfg.length_offset_q12 <= RST_LENGTH_OFFSET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STD_THRESHOLD: cfg.std_threshold     <= cfg_data[THR_BITS-1:0];
        CFG_START_RUN:     cfg.start_run         <= cfg_data[RUN_BITS-1:0];
        CFG_STOP_RUN:      cfg.stop_run          <= cfg_data[RUN_BITS-1:0];
        CFG_MIN_EVENT:     cfg.min_event_frames  <= cfg_data[RUN_BITS-1:0];
        CFG_LENGTH_SCALE:  cfg.length_scale_q12  <= cfg_data[SCALE_BITS-1:0];
        CFG_LENGTH_OFFSET: cfg.length_offset_q12 <= $signed(cfg_data[OFFSET_BITS-1:0]);
        default: ;
      endcase
    end
  end

  wsad_front #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .q_full   (q_full),
    .push     (push),
    .flags    (f_flags),
    .count    (f_count)
  );

  wsad_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_flags, f_count}),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Split the queue entry back into flags and frame count
  assign q_flags = q_rdata[ENTRY_W-1:COUNT_BITS];
  assign q_count = q_rdata[COUNT_BITS-1:0];

  wsad_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_flags      (q_flags),
    .q_count      (q_count),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_start  (event_start),
    .event_end    (event_end),
    .too_short    (too_short),
    .event_frames (event_frames),
    .length_q12   (length_q12)
  );

endmodule

// File: tb/wsad_activity_checker.sv
// Scoreboard for the windowed standard deviation activity detector: mirrors the
// detector state from accepted samples and register writes, checks every result beat.
// Depends on wsad_pkg only.
module wsad_activity_checker
  import wsad_pkg::*;
#(
  parameter int WINDOW_LEN  = 5,
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       event_start,
  input  logic                       event_end,
  input  logic                       too_short,
  input  logic [FRAME_BITS-1:0]      event_frames,
  input  logic signed [LEN_BITS-1:0] length_q12,
  output int unsigned                beats_checked,
  output int unsigned                mismatches,
  output int unsigned                starts_seen,
  output int unsigned                measured_seen,
  output int unsigned                short_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                       evt_start;
    logic                       evt_end;
    logic                       evt_short;
    logic [FRAME_BITS-1:0]      frames;
    logic signed [LEN_BITS-1:0] len_q12;
  } activity_result_t;

  // Mirror of the detector state
  logic [SAMPLE_BITS-1:0] window_q [WINDOW_LEN];
  logic [RUN_BITS-1:0]    busy_len;
  logic [RUN_BITS-1:0]    quiet_len;
  logic                   in_evt;
  logic [COUNT_BITS-1:0]  frame_count;

  // Mirror of the register file
  logic [THR_BITS-1:0]           threshold_reg;
  logic [RUN_BITS-1:0]           start_reg;
  logic [RUN_BITS-1:0]           stop_reg;
  logic [RUN_BITS-1:0]           min_frames_reg;
  logic [SCALE_BITS-1:0]         scale_reg;
  logic signed [OFFSET_BITS-1:0] offset_reg;

  activity_result_t predicted_beats[$];

  initial begin
    beats_checked = 0;
    mismatches    = 0;
    starts_seen   = 0;
    measured_seen = 0;
    short_seen    = 0;
  end

  // Count each mismatch and print one line for each of the first 40; keep the log short on a broken build
  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Variance test without a square root: N*sum_sq - sum^2 >= N^2 * T^2
  function automatic logic window_busy();
    longint total    = 0;
    longint total_sq = 0;
    longint thr;
    foreach (window_q[i]) begin
      total    += longint'(window_q[i]);
      total_sq += longint'(window_q[i]) * longint'(window_q[i]);
    end
    thr = longint'(threshold_reg);
    return (WINDOW_LEN * total_sq - total * total) >= (WINDOW_LEN * WINDOW_LEN * thr * thr);
  endfunction

  // Take one sample through the window and the run counters, give the result beat
  function automatic activity_result_t advance_detector(logic [SAMPLE_BITS-1:0] s);
    activity_result_t r;
    longint frames_l;
    longint len;
    r.evt_start = 1'b0;
    r.evt_end   = 1'b0;
    r.evt_short = 1'b0;
    r.frames    = '0;
    r.len_q12   = '0;
    for (int i = 0; i < WINDOW_LEN - 1; i++)
      window_q[i] = window_q[i + 1];
    window_q[WINDOW_LEN - 1] = s;

    if (window_busy()) begin
      if (busy_len != RUN_MAX) busy_len++;
      quiet_len = '0;
      if (in_evt && frame_count != '1) frame_count++;
      if (!in_evt && busy_len >= start_reg) begin
        in_evt      = 1'b1;
        busy_len    = '0;
        frame_count = '0;
        r.evt_start = 1'b1;
      end
    end else begin
      if (quiet_len != RUN_MAX) quiet_len++;
      busy_len = '0;
      if (in_evt && frame_count != '1) frame_count++;
      if (in_evt && quiet_len >= stop_reg) begin
        frames_l    = longint'(frame_count);
        in_evt      = 1'b0;
        quiet_len   = '0;
        frame_count = '0;
        r.frames = (frames_l > longint'(FRAME_MAX)) ? FRAME_MAX : frames_l[FRAME_BITS-1:0];
        if (frames_l < longint'(min_frames_reg)) begin
          r.evt_short = 1'b1;
        end else begin
          len = frames_l * longint'(scale_reg) + longint'(offset_reg);
          if (len > LEN_MAX) len = LEN_MAX;
          if (len < LEN_MIN) len = LEN_MIN;
          r.evt_end = 1'b1;
          r.len_q12 = len[LEN_BITS-1:0];
        end
      end
    end
    return r;
  endfunction

  // Track writes and samples, compare each result beat with the oldest prediction
  always @(posedge clk) begin
    activity_result_t want;
    if (rst) begin
      foreach (window_q[i]) window_q[i] = '0;
      busy_len       = '0;
      quiet_len      = '0;
      in_evt         = 1'b0;
      frame_count    = '0;
      threshold_reg  = RST_STD_THRESHOLD;
      start_reg      = RST_START_RUN;
      stop_reg       = RST_STOP_RUN;
      min_frames_reg = RST_MIN_EVENT;
      scale_reg      = RST_LENGTH_SCALE;
      offset_reg     = RST_LENGTH_OFFSET;
      predicted_beats.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_STD_THRESHOLD: threshold_reg  = cfg_data[THR_BITS-1:0];
          CFG_START_RUN:     start_reg      = cfg_data[RUN_BITS-1:0];
          CFG_STOP_RUN:      stop_reg       = cfg_data[RUN_BITS-1:0];
          CFG_MIN_EVENT:     min_frames_reg = cfg_data[RUN_BITS-1:0];
          CFG_LENGTH_SCALE:  scale_reg      = cfg_data[SCALE_BITS-1:0];
          CFG_LENGTH_OFFSET: offset_reg     = cfg_data[OFFSET_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predicted_beats.push_back(advance_detector(sample));
      if (out_valid && !out_stall) begin
        beats_checked <= beats_checked + 1;
        if (predicted_beats.size() == 0) begin
          report_mismatch("result beat with nothing pending", 0, 1);
        end else begin
          want = predicted_beats.pop_front();
          if (event_start !== want.evt_start)
            report_mismatch("event_start", want.evt_start, event_start);
          if (event_end !== want.evt_end)
            report_mismatch("event_end", want.evt_end, event_end);
          if (too_short !== want.evt_short)
            report_mismatch("too_short", want.evt_short, too_short);
          if (event_frames !== want.frames)
            report_mismatch("event_frames", want.frames, event_frames);
          if (length_q12 !== want.len_q12)
            report_mismatch("length_q12", want.len_q12, length_q12);
          if (want.evt_start) starts_seen++;
          if (want.evt_end)   measured_seen++;
          if (want.evt_short) short_seen++;
        end
      end
    end
  end

endmodule

// File: tb/windowed_stddev_activity_detector_top_test.sv
// Testbench top for the windowed standard deviation activity detector: drives samples,
// register writes and result stalls, and gives the verdict.
// Depends on wsad_pkg, the detector RTL and wsad_activity_checker.
module windowed_stddev_activity_detector_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wsad_pkg::*;

  localparam int WINDOW_LEN  = 5;
  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;

  localparam int unsigned RANDOM_ITEMS       = 1500;
  localparam int unsigned LONG_EVENT_SAMPLES = 65600;
  localparam int unsigned CYCLE_LIMIT        = 1_000_000;
  localparam int unsigned SETTLE_CYCLES      = 12;
  localparam int unsigned SAMPLE_MAX         = (1 << SAMPLE_BITS) - 1;

  localparam logic [SAMPLE_BITS-1:0] RAIL_LOW  = '0;
  localparam logic [SAMPLE_BITS-1:0] RAIL_HIGH = '1;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MOST_NEG = {1'b1, {(OFFSET_BITS-1){1'b0}}};
  localparam logic [OFFSET_BITS-1:0] OFFSET_MOST_POS = {1'b0, {(OFFSET_BITS-1){1'b1}}};

  typedef enum logic [1:0] {BURST_QUIET, BURST_BUSY, BURST_NOISE} burst_kind_e;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic [SAMPLE_BITS-1:0]     sample    = '0;
  logic                       out_stall = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic                       event_start;
  logic                       event_end;
  logic                       too_short;
  logic [FRAME_BITS-1:0]      event_frames;
  logic signed [LEN_BITS-1:0] length_q12;

  int unsigned beats_checked;
  int unsigned mismatches;
  int unsigned starts_seen;
  int unsigned measured_seen;
  int unsigned short_seen;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned settings_used  = 0;
  bit          in_gaps        = 1'b0;
  bit          out_gaps       = 1'b0;

  windowed_stddev_activity_detector_top #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) uut (.*);

  wsad_activity_checker #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) result_monitor (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[windowed_stddev_activity_detector_top] ERROR");
      $finish;
    end
  end

  // Result side: when out_gaps is set, stall for a random number of cycles ahead of each beat
  initial begin
    int unsigned hold;
    forever begin
      hold = out_gaps ? $urandom_range(0, 8) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one sample beat, after a random gap when in_gaps is set, and hold it until taken
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] value);
    int unsigned gap;
    gap = in_gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // Write one register; bits above its width carry random junk
  task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] value, input int width);
    logic [CFG_DATA_BITS-1:0] keep;
    keep = (CFG_DATA_BITS'(1) << width) - 1'b1;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (CFG_DATA_BITS'($urandom) & ~keep) | (value & keep);
    @(posedge clk);
  endtask

  // Drop valid and wait until every sample has produced its result beat
  task automatic drain();
    in_valid <= 1'b0;
    while (beats_checked != items_sent) @(posedge clk);
  endtask

  // Busy bursts swing around a base level, quiet ones wander by at most amp, noise ones span the full range
  task automatic play_burst(input burst_kind_e kind, input int unsigned len,
                            input int unsigned amp);
    int unsigned base;
    int unsigned level;
    base = $urandom_range(amp, SAMPLE_MAX - amp);
    for (int unsigned k = 0; k < len; k++) begin
      case (kind)
        BURST_BUSY:  level = k[0] ? base + amp : base - amp;
        BURST_QUIET: level = base + $urandom_range(0, amp);
        default:     level = $urandom_range(0, SAMPLE_MAX);
      endcase
      push_sample(level[SAMPLE_BITS-1:0]);
    end
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase;
    burst_kind_e rest_kind;
    logic [THR_BITS-1:0]    thr;
    logic [RUN_BITS-1:0]    start_v;
    logic [RUN_BITS-1:0]    stop_v;
    logic [RUN_BITS-1:0]    min_v;
    logic [SCALE_BITS-1:0]  scale_v;
    logic [OFFSET_BITS-1:0] offset_v;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: swing between the rails to open an event, hold the top rail to close it
    for (int k = 0; k < 10; k++) push_sample(k[0] ? RAIL_HIGH : RAIL_LOW);
    repeat (13) push_sample(RAIL_HIGH);
    push_sample(SAMPLE_BITS'('h555));
    push_sample(SAMPLE_BITS'('hAAA));

    // Random settings, first the low and high extremes, then random values; each setting plays bursts of activity
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      drain();
      thr = $urandom_range(20, 700);
      case (phase)
        0: begin
          start_v  = '0;
          stop_v   = '0;
          min_v    = '0;
          scale_v  = '0;
          offset_v = OFFSET_MOST_NEG;
        end
        1: begin
          start_v  = 1;
          stop_v   = 1;
          min_v    = '1;
          scale_v  = '1;
          offset_v = OFFSET_MOST_POS;
        end
        default: begin
          start_v  = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(0, 8);
          stop_v   = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(0, 12);
          case ($urandom_range(0, 6))
            0:       min_v = 1;
            1:       min_v = 2;
            2:       min_v = '1;
            default: min_v = $urandom_range(0, 40);
          endcase
          scale_v  = $urandom_range(0, 65535);
          offset_v = OFFSET_BITS'($urandom);
        end
      endcase
      set_reg(CFG_STD_THRESHOLD, thr, THR_BITS);
      set_reg(CFG_START_RUN, start_v, RUN_BITS);
      set_reg(CFG_STOP_RUN, stop_v, RUN_BITS);
      set_reg(CFG_MIN_EVENT, min_v, RUN_BITS);
      set_reg(CFG_LENGTH_SCALE, scale_v, SCALE_BITS);
      set_reg(CFG_LENGTH_OFFSET, offset_v, OFFSET_BITS);
      cfg_write <= 1'b0;
      settings_used++;
      in_gaps  = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      repeat (6) begin
        play_burst(BURST_BUSY, start_v + $urandom_range(0, 40), $urandom_range(0, 1200));
        rest_kind = BURST_QUIET;
        if ($urandom_range(0, 4) == 0) rest_kind = BURST_NOISE;
        play_burst(rest_kind, $urandom_range(0, stop_v + 6), $urandom_range(0, 3));
      end
      phase++;
    end

    // Longest start and stop runs; the run counters reach their ceiling
    drain();
    set_reg(CFG_STD_THRESHOLD, 200, THR_BITS);
    set_reg(CFG_START_RUN, RUN_MAX, RUN_BITS);
    set_reg(CFG_STOP_RUN, RUN_MAX, RUN_BITS);
    set_reg(CFG_MIN_EVENT, $urandom_range(2, 255), RUN_BITS);
    cfg_write <= 1'b0;
    settings_used++;
    repeat (2) begin
      play_burst(BURST_BUSY, 300, $urandom_range(600, 1500));
      play_burst(BURST_QUIET, 300, $urandom_range(0, 3));
    end

    // Zero threshold keeps every sample busy until the frame count saturates,
    // then the top threshold ends the event with the largest length
    drain();
    set_reg(CFG_STD_THRESHOLD, '0, THR_BITS);
    set_reg(CFG_START_RUN, 1, RUN_BITS);
    set_reg(CFG_STOP_RUN, 1, RUN_BITS);
    set_reg(CFG_MIN_EVENT, 2, RUN_BITS);
    set_reg(CFG_LENGTH_SCALE, '1, SCALE_BITS);
    set_reg(CFG_LENGTH_OFFSET, OFFSET_MOST_POS, OFFSET_BITS);
    cfg_write <= 1'b0;
    settings_used++;
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    repeat (LONG_EVENT_SAMPLES) push_sample($urandom_range(0, SAMPLE_MAX));
    drain();
    set_reg(CFG_STD_THRESHOLD, '1, THR_BITS);
    cfg_write <= 1'b0;
    settings_used++;
    repeat (3) push_sample($urandom_range(0, SAMPLE_MAX));

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples under %0d register settings, bursts and a saturating event.",
             items_sent, settings_used);
    $display("Checked %0d beats: %0d events started, %0d measured, %0d too short.",
             beats_checked, starts_seen, measured_seen, short_seen);
    if (mismatches == 0 && beats_checked == items_sent)
      $display("[windowed_stddev_activity_detector_top] OK");
    else
      $display("[windowed_stddev_activity_detector_top] ERROR");
    $finish;
  end

endmodule
